// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

   localparam int DATA_W = 18;
   localparam int NUM_W  = DATA_W + 1;
   // wide enough for the square-root argument at any supported fraction width
   localparam int ARG_W  = 32;

   localparam logic [1:0] IDX_X = 2'd0;
   localparam logic [1:0] IDX_Y = 2'd1;
   localparam logic [1:0] IDX_Z = 2'd2;
   localparam logic [1:0] IDX_W = 2'd3;

   localparam logic signed [DATA_W-1:0] Q_MAX = 18'sh1FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 18'sh20000;

   typedef struct packed {
      logic                        degen;
      logic [1:0]                  dom;
      logic [2:0][1:0]             slot;
      logic [2:0][NUM_W-1:0]       num;
      logic [ARG_W-1:0]            arg;
   } rmq_item_type;

   function automatic logic [1:0] rmq_succ(input logic [1:0] idx);
      logic [1:0] nxt;
      unique case (idx)
         IDX_X:   nxt = IDX_Y;
         IDX_Y:   nxt = IDX_Z;
         default: nxt = IDX_X;
      endcase
      return nxt;
   endfunction

endpackage

// ===== rtl/rmq_fifo.sv =====
module rmq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/rmq_front.sv =====
module rmq_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic signed [rmq_pkg::DATA_W-1:0] m00,
   input  logic signed [rmq_pkg::DATA_W-1:0] m01,
   input  logic signed [rmq_pkg::DATA_W-1:0] m02,
   input  logic signed [rmq_pkg::DATA_W-1:0] m10,
   input  logic signed [rmq_pkg::DATA_W-1:0] m11,
   input  logic signed [rmq_pkg::DATA_W-1:0] m12,
   input  logic signed [rmq_pkg::DATA_W-1:0] m20,
   input  logic signed [rmq_pkg::DATA_W-1:0] m21,
   input  logic signed [rmq_pkg::DATA_W-1:0] m22,
   output rmq_pkg::rmq_item_type             item
);
   import rmq_pkg::*;

   logic signed [DATA_W-1:0] mat [3][3];
   logic signed [DATA_W+1:0] trace;
   logic signed [ARG_W-1:0]  one;
   logic signed [ARG_W-1:0]  arg;
   logic [1:0]               i_idx, j_idx, k_idx;

   assign mat[0][0] = m00;
   assign mat[0][1] = m01;
   assign mat[0][2] = m02;
   assign mat[1][0] = m10;
   assign mat[1][1] = m11;
   assign mat[1][2] = m12;
   assign mat[2][0] = m20;
   assign mat[2][1] = m21;
   assign mat[2][2] = m22;

   assign one   = ARG_W'(1) <<< FRAC_BITS;
   assign trace = (DATA_W+2)'(m00) + (DATA_W+2)'(m11) + (DATA_W+2)'(m22);

   always_comb begin
      // ties keep the lower diagonal index
      i_idx = IDX_X;
      if (m11 > m00) begin
         i_idx = IDX_Y;
      end
      if (m22 > mat[i_idx][i_idx]) begin
         i_idx = IDX_Z;
      end
      j_idx = rmq_succ(i_idx);
      k_idx = rmq_succ(j_idx);

      if (trace > 0) begin
         arg         = ARG_W'(trace) + one;
         item.dom    = IDX_W;
         item.num[0] = NUM_W'(m21) - NUM_W'(m12);
         item.num[1] = NUM_W'(m02) - NUM_W'(m20);
         item.num[2] = NUM_W'(m10) - NUM_W'(m01);
         item.slot[0] = IDX_X;
         item.slot[1] = IDX_Y;
         item.slot[2] = IDX_Z;
      end else begin
         arg = ARG_W'(mat[i_idx][i_idx]) - ARG_W'(mat[j_idx][j_idx])
             - ARG_W'(mat[k_idx][k_idx]) + one;
         item.dom    = i_idx;
         item.num[0] = NUM_W'(mat[k_idx][j_idx]) - NUM_W'(mat[j_idx][k_idx]);
         item.num[1] = NUM_W'(mat[j_idx][i_idx]) + NUM_W'(mat[i_idx][j_idx]);
         item.num[2] = NUM_W'(mat[k_idx][i_idx]) + NUM_W'(mat[i_idx][k_idx]);
         item.slot[0] = IDX_W;
         item.slot[1] = j_idx;
         item.slot[2] = k_idx;
      end
      item.arg   = arg;
      item.degen = (arg <= 0);
   end

endmodule

// ===== rtl/rmq_back.sv =====
module rmq_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              mid_empty,
   input  rmq_pkg::rmq_item_type             mid_item,
   output logic                              mid_pop,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qx,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qy,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qz,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qw,
   output logic                              rsp_degenerate
);
   import rmq_pkg::*;

   // positive argument width, radicand width, root width, quotient width
   localparam int AW = (FRAC_BITS + 1 > 19) ? FRAC_BITS + 1 : 19;
   localparam int RW = AW + FRAC_BITS;
   localparam int SW = (RW + 1) / 2;
   localparam int NQ = NUM_W + FRAC_BITS;
   localparam int NS = SW + NQ;

   typedef struct packed {
      rmq_item_type           item;
      logic [2*SW-1:0]        rad;
      logic [SW+1:0]          rem;
      logic [SW-1:0]          root;
      logic [2:0][NQ-1:0]     dq;
      logic [2:0][SW+1:0]     drem;
   } stage_type;

   stage_type head;
   stage_type src     [NS];
   stage_type step_in [NS];
   stage_type pipe_ff [NS];
   logic      vld_ff  [NS];
   logic      en;

   logic                     out_vld_ff;
   logic signed [DATA_W-1:0] q_ff [4];
   logic signed [DATA_W-1:0] q_in [4];
   logic                     degen_ff;

   assign en        = !out_vld_ff || rsp_pop;
   assign mid_pop   = en && !mid_empty;
   assign rsp_empty = !out_vld_ff;

   always_comb begin
      logic [NUM_W-1:0] mag;
      head      = '0;
      head.item = mid_item;
      if (!mid_item.degen) begin
         head.rad = (2*SW)'({mid_item.arg[AW-1:0], FRAC_BITS'(0)});
      end
      for (int n = 0; n < 3; n++) begin
         mag = mid_item.num[n][NUM_W-1] ? NUM_W'(-mid_item.num[n]) : mid_item.num[n];
         head.dq[n] = NQ'({mag, FRAC_BITS'(0)});
      end
   end

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_stage
         if (k == 0) begin : g_head
            assign src[k] = head;
         end else begin : g_link
            assign src[k] = pipe_ff[k-1];
         end

         if (k < SW) begin : g_sqrt
            // one root bit per stage
            always_comb begin
               logic [SW+2:0] rt;
               logic [SW+2:0] trial;
               step_in[k]     = src[k];
               rt             = {src[k].rem[SW:0], src[k].rad[2*SW-1 -: 2]};
               trial          = (SW+3)'({src[k].root, 2'b01});
               step_in[k].rad = src[k].rad << 2;
               if (rt >= trial) begin
                  step_in[k].rem  = (SW+2)'(rt - trial);
                  step_in[k].root = {src[k].root[SW-2:0], 1'b1};
               end else begin
                  step_in[k].rem  = (SW+2)'(rt);
                  step_in[k].root = {src[k].root[SW-2:0], 1'b0};
               end
            end
         end else begin : g_div
            // one quotient bit per stage for all three lanes, divisor is 2*s
            always_comb begin
               logic [SW+1:0] rt;
               logic [SW+1:0] dvs;
               step_in[k] = src[k];
               dvs        = (SW+2)'({src[k].root, 1'b0});
               for (int n = 0; n < 3; n++) begin
                  rt = {src[k].drem[n][SW:0], src[k].dq[n][NQ-1]};
                  step_in[k].dq[n] = src[k].dq[n] << 1;
                  if (rt >= dvs) begin
                     step_in[k].drem[n]  = rt - dvs;
                     step_in[k].dq[n][0] = 1'b1;
                  end else begin
                     step_in[k].drem[n] = rt;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en) begin
               if (k == 0) begin
                  vld_ff[k] <= mid_pop;
               end else begin
                  vld_ff[k] <= vld_ff[k == 0 ? 0 : k-1];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               pipe_ff[k] <= step_in[k];
            end
         end
      end
   endgenerate

   // saturate, restore signs and route the lanes to their components
   always_comb begin
      stage_type                lst;
      logic [SW-2:0]            half;
      logic signed [DATA_W-1:0] dom_val;
      logic signed [DATA_W-1:0] oth [3];
      logic [NQ-1:0]            qq;
      logic [NQ-1:0]            nq;
      logic                     neg;
      logic                     nz;
      lst  = pipe_ff[NS-1];
      half = lst.root[SW-1:1];
      if (lst.item.degen) begin
         dom_val = '0;
      end else if ((SW-1)'(half) > (SW-1)'(Q_MAX)) begin
         dom_val = Q_MAX;
      end else begin
         dom_val = DATA_W'(half);
      end
      for (int n = 0; n < 3; n++) begin
         qq  = lst.dq[n];
         nq  = -qq;
         neg = lst.item.num[n][NUM_W-1];
         nz  = (lst.item.num[n] != '0);
         if (lst.item.degen) begin
            oth[n] = !nz ? '0 : (neg ? Q_MIN : Q_MAX);
         end else if (neg) begin
            oth[n] = (qq > NQ'(Q_MAX) + 1'b1) ? Q_MIN : nq[DATA_W-1:0];
         end else begin
            oth[n] = (qq > NQ'(Q_MAX)) ? Q_MAX : qq[DATA_W-1:0];
         end
      end
      for (int c = 0; c < 4; c++) begin
         q_in[c] = '0;
      end
      q_in[lst.item.dom] = dom_val;
      for (int n = 0; n < 3; n++) begin
         q_in[lst.item.slot[n]] = oth[n];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            q_ff[c] <= q_in[c];
         end
         degen_ff <= pipe_ff[NS-1].item.degen;
      end
   end

   assign rsp_qx         = q_ff[IDX_X];
   assign rsp_qy         = q_ff[IDX_Y];
   assign rsp_qz         = q_ff[IDX_Z];
   assign rsp_qw         = q_ff[IDX_W];
   assign rsp_degenerate = degen_ff;

endmodule

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// Converts a 3x3 rotation matrix (signed fixed point, FRAC_BITS fraction bits) into
// the unit quaternion x, y, z, w. One matrix is taken per clock while the queue is
// not full, and one quaternion leaves per clock while rsp_pop is high. The back end
// has SW = ceil((max(19, FRAC_BITS + 1) + FRAC_BITS) / 2) square-root stages and
// NQ = 19 + FRAC_BITS division stages: the front end picks the case and forms the
// square-root argument, a four-entry queue holds it, and the back end runs a
// bit-per-stage square root and three bit-per-stage dividers in lockstep. When pop
// holds the result, the back-end pipeline freezes and the queue keeps taking
// matrices until full.
module rotation_matrix_to_quaternion_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m00,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m01,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m02,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m10,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m11,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m12,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m20,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m21,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m22,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qx,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qy,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qz,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qw,
   output logic                              rsp_degenerate
);
   import rmq_pkg::*;

   rmq_item_type front_item;
   rmq_item_type mid_item;
   logic         mid_empty;
   logic         mid_pop;

   rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .m00(req_m00), .m01(req_m01), .m02(req_m02),
      .m10(req_m10), .m11(req_m11), .m12(req_m12),
      .m20(req_m20), .m21(req_m21), .m22(req_m22),
      .item(front_item)
   );

   rmq_fifo #(.WIDTH($bits(rmq_item_type)), .DEPTH(4)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(front_item),
      .full     (req_full),
      .pop      (mid_pop),
      .empty    (mid_empty),
      .pop_data (mid_item)
   );

   rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .mid_empty     (mid_empty),
      .mid_item      (mid_item),
      .mid_pop       (mid_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_qx        (rsp_qx),
      .rsp_qy        (rsp_qy),
      .rsp_qz        (rsp_qz),
      .rsp_qw        (rsp_qw),
      .rsp_degenerate(rsp_degenerate)
   );

endmodule

// ===== rtl/rmq_checker.sv =====
module rmq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_push,
   input logic                              req_full,
   input logic                              rsp_empty,
   input logic                              rsp_pop,
   input logic signed [rmq_pkg::DATA_W-1:0] rsp_qx,
   input logic signed [rmq_pkg::DATA_W-1:0] rsp_qy,
   input logic signed [rmq_pkg::DATA_W-1:0] rsp_qz,
   input logic signed [rmq_pkg::DATA_W-1:0] rsp_qw,
   input logic                              rsp_degenerate
);
   import rmq_pkg::*;

   // nothing is queued or waiting right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue not clear after reset");

   // a waiting result holds until its transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_qx) && $stable(rsp_qy)
         && $stable(rsp_qz) && $stable(rsp_qw) && $stable(rsp_degenerate))
      else $error("result changed while stalled");

   // degenerate results only carry saturated or zero components
   a_degen: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_degenerate |->
         (rsp_qx == Q_MAX || rsp_qx == Q_MIN || rsp_qx == '0) &&
         (rsp_qy == Q_MAX || rsp_qy == Q_MIN || rsp_qy == '0) &&
         (rsp_qz == Q_MAX || rsp_qz == Q_MIN || rsp_qz == '0) &&
         (rsp_qw == Q_MAX || rsp_qw == Q_MIN || rsp_qw == '0))
      else $error("degenerate result has unsaturated component");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);
